/* src/kmds_pkg.sv */
// ----------------------------------------------------------------------------
// kmds_pkg
// shared widths, defaults and types of the key matrix debounce scanner
// ----------------------------------------------------------------------------
`default_nettype none

package kmds_pkg;

  localparam int unsigned RowIdxW   = 2;
  localparam int unsigned InColsW   = 12;
  localparam int unsigned MatrixW   = 48;
  localparam int unsigned CountW    = 4;
  localparam int unsigned InDataW   = 16;
  localparam int unsigned OutDataW  = 48;
  localparam int unsigned DefRows   = 4;
  localparam int unsigned DefCols   = 12;

  localparam logic [CountW-1:0] ThreshReset = CountW'(10);

  typedef struct packed {
    logic               valid;
    logic               last;
    logic [RowIdxW-1:0] row;
  } kmds_step_t;

endpackage

`default_nettype wire

/* src/kmds_lane.sv */
// ----------------------------------------------------------------------------
// kmds_lane
// debounce counters of one matrix column, one counter per row
// ----------------------------------------------------------------------------
`default_nettype none

module kmds_lane #(
  parameter int unsigned ROWS = kmds_pkg::DefRows
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic [kmds_pkg::RowIdxW-1:0] row_i,
  input  wire logic                         active_i,
  input  wire logic [kmds_pkg::CountW-1:0]  thresh_i,
  output logic                              pressed_o
);
  import kmds_pkg::*;

  localparam int unsigned RowW = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [CountW-1:0] cnt_q [ROWS];
  logic [CountW-1:0] cnt_cur;
  logic [CountW-1:0] cnt_d;
  logic [RowW-1:0]   sel;
  logic              at_thresh;

  assign sel       = row_i[RowW-1:0];
  assign cnt_cur   = cnt_q[sel];
  assign at_thresh = (cnt_cur >= thresh_i);
  assign pressed_o = active_i & at_thresh;

  always_comb begin
    if (!active_i) begin
      cnt_d = '0;
    end else if (at_thresh) begin
      cnt_d = cnt_cur;
    end else begin
      cnt_d = cnt_cur + CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        cnt_q[r] <= '0;
      end
    end else if (en_i) begin
      cnt_q[sel] <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* src/kmds_merge.sv */
// ----------------------------------------------------------------------------
// kmds_merge
// collects lane press bits into the scan report and holds finished reports
// ----------------------------------------------------------------------------
`default_nettype none

module kmds_merge #(
  parameter int unsigned ROWS = kmds_pkg::DefRows,
  parameter int unsigned COLS = kmds_pkg::DefCols
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire kmds_pkg::kmds_step_t          step_i,
  input  wire logic [COLS-1:0]               press_i,
  output logic                               ready_o,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [kmds_pkg::OutDataW-1:0]      m_axis_tdata
);
  import kmds_pkg::*;

  localparam int unsigned Keys = ROWS * COLS;

  logic [Keys-1:0]     report_q, report_d, report_upd;
  logic [63:0]         report_ext;
  logic [MatrixW-1:0]  result;
  logic                emit;
  logic                take;
  logic                out_valid_q;
  logic [MatrixW-1:0]  out_data_q;
  logic                skid_valid_q;
  logic [MatrixW-1:0]  skid_data_q;

  always_comb begin
    report_upd = report_q;
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        if (step_i.row == RowIdxW'(r)) begin
          report_upd[r*COLS+c] = report_q[r*COLS+c] | press_i[c];
        end
      end
    end
  end

  assign report_ext = 64'(report_upd);
  assign result     = report_ext[MatrixW-1:0];
  assign emit       = step_i.valid & step_i.last;
  assign take       = out_valid_q & m_axis_tready;

  always_comb begin
    report_d = report_q;
    if (step_i.valid) begin
      report_d = step_i.last ? '0 : report_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      report_q     <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      report_q <= report_d;
      if (emit) begin
        if (!out_valid_q || take) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (take) begin
        out_valid_q  <= skid_valid_q;
        skid_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      if (!out_valid_q || take) begin
        out_data_q <= result;
      end else begin
        skid_data_q <= result;
      end
    end else if (take && skid_valid_q) begin
      out_data_q <= skid_data_q;
    end
  end

  assign ready_o       = ~skid_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(out_data_q);

endmodule

`default_nettype wire

/* src/key_matrix_debounce_scanner_top.sv */
// ----------------------------------------------------------------------------
// key_matrix_debounce_scanner_top
// debounced scan of a ROWS x COLS key matrix, one row sample per beat
//
// input stream: one beat per sampled row, row number and column levels.
// each column has its own lane of per-row debounce counters, all lanes work
// in the same cycle, so a row beat is taken every cycle while s_axis_tready is high.
// a key is marked pressed once it reads active with its counter at or above
// the threshold; a released key clears its counter.
// the beat of the last row closes the scan: the pressed map is registered
// into the output or skid stage and the report starts over empty.
// rows beyond ROWS are dropped without effect.
// output stream: one beat per scan, held in an output register plus a
// one-deep skid stage; s_axis_tready falls only while both are full.
// cfg_we_i writes the threshold at once, to be done while the block idles.
// reset clears all counters and the report, threshold returns to 10.
// ----------------------------------------------------------------------------
`default_nettype none

module key_matrix_debounce_scanner_top #(
  parameter int unsigned ROWS = kmds_pkg::DefRows,
  parameter int unsigned COLS = kmds_pkg::DefCols
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [kmds_pkg::CountW-1:0]  cfg_wdata_i,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // [1:0] row_index, [13:2] column_levels, [15:14] zero
  input  wire logic [kmds_pkg::InDataW-1:0] s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // [47:0] key_map
  output logic [kmds_pkg::OutDataW-1:0]     m_axis_tdata
);
  import kmds_pkg::*;

  logic [CountW-1:0]  thresh_q;
  logic [RowIdxW-1:0] row_index;
  logic [InColsW-1:0] column_levels;
  logic               accept;
  logic               row_ok;
  logic [COLS-1:0]    press;
  kmds_step_t         step;

  assign row_index     = s_axis_tdata[RowIdxW-1:0];
  assign column_levels = s_axis_tdata[RowIdxW +: InColsW];
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign row_ok        = (32'(row_index) < ROWS);

  assign step.valid = accept & row_ok;
  assign step.last  = (32'(row_index) == ROWS - 1);
  assign step.row   = row_index;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThreshReset;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  for (genvar c = 0; c < COLS; c++) begin : g_lane
    logic active;
    if (c < InColsW) begin : g_in
      assign active = column_levels[c];
    end else begin : g_none
      assign active = 1'b0;
    end

    kmds_lane #(
      .ROWS (ROWS)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (step.valid),
      .row_i     (row_index),
      .active_i  (active),
      .thresh_i  (thresh_q),
      .pressed_o (press[c])
    );
  end

  kmds_merge #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .press_i       (press),
    .ready_o       (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire
